// ===== hw/rtl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared widths, register indexes, pixel side-band type and output saturation
// for the depth pixel to point pipeline.
// ----------------------------------------------------------------------------
package dpp_pkg;

	localparam int TAN_W   = 18;
	localparam int REF_W   = 13;
	localparam int SCALE_W = 16;
	localparam int DEPTH_W = 16;
	localparam int COL_W   = 8;
	localparam int CFG_W   = 18;
	localparam int ADDR_W  = 3;
	localparam int VEC_W   = 31;
	localparam int N2_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int DEN_W   = ROOT_W + SCALE_W;
	localparam int PNUM_W  = 64;
	localparam int PQ_W    = 24;
	localparam int OUT_W   = 24;

	localparam logic [VEC_W-1:0] VEC_MAX = {VEC_W{1'b1}};
	localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [ADDR_W-1:0] {
		REG_TAN_H   = 3'd0,
		REG_TAN_V   = 3'd1,
		REG_WIDTH   = 3'd2,
		REG_HEIGHT  = 3'd3,
		REG_SCALE   = 3'd4
	} dpp_reg_t;

	typedef struct packed {
		logic               frame_end;
		logic [DEPTH_W-1:0] depth;
		logic [COL_W-1:0]   red;
		logic [COL_W-1:0]   green;
		logic [COL_W-1:0]   blue;
	} dpp_pix_t;

	function automatic logic [OUT_W-1:0] sat_out(input logic [PQ_W-1:0] q,
		input logic ovf, input logic neg);
		logic [OUT_W-1:0] mag;
		begin
			if (neg) begin
				mag = (ovf || q > OUT_NEG_MAG) ? OUT_NEG_MAG : q;
				sat_out = OUT_W'(0) - mag;
			end else begin
				sat_out = (ovf || q > OUT_POS_MAX) ? OUT_POS_MAX : q;
			end
		end
	endfunction

endpackage

// ===== hw/rtl/dpp_div.sv =====
// ----------------------------------------------------------------------------
// dpp_div
// Restoring divider, one quotient bit per stage, with overflow flag when the
// quotient does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module dpp_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 48,
	parameter int Q_W   = 24
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);
	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [NUM_W-1:0] rem_q [Q_W+1];
	logic [DEN_W-1:0] den_q [Q_W+1];
	logic [Q_W-1:0]   quo_q [Q_W+1];
	logic             ovf_q [Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num;
			den_q[0] <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= CW'(num) >= (CW'(den) << Q_W);
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		localparam int B = Q_W - k;
		logic [CW-1:0] trial;
		logic [CW-1:0] diff;
		logic          take;

		assign trial = CW'(den_q[k-1]) << B;
		assign take  = CW'(rem_q[k-1]) >= trial;
		assign diff  = CW'(rem_q[k-1]) - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? diff[NUM_W-1:0] : rem_q[k-1];
				den_q[k] <= den_q[k-1];
				quo_q[k] <= quo_q[k-1] | (Q_W'(take) << B);
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	assign quo = quo_q[Q_W];
	assign ovf = ovf_q[Q_W];

endmodule

// ===== hw/rtl/dpp_isqrt.sv =====
// ----------------------------------------------------------------------------
// dpp_isqrt
// Floor square root of a 64-bit value, digit by digit, one root bit per stage.
// ----------------------------------------------------------------------------
module dpp_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dpp_pkg::N2_W-1:0]   val,
	output logic [dpp_pkg::ROOT_W-1:0] root
);
	import dpp_pkg::*;

	localparam int RW = ROOT_W + 2;

	logic [N2_W-1:0]   val_q  [ROOT_W+1];
	logic [RW-1:0]     rem_q  [ROOT_W+1];
	logic [ROOT_W-1:0] root_q [ROOT_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			val_q[0]  <= val;
			rem_q[0]  <= '0;
			root_q[0] <= '0;
		end
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
		logic [RW+1:0] remn;
		logic [RW+1:0] trial;
		logic [RW+1:0] diff;
		logic          take;

		assign remn  = {rem_q[k-1], val_q[k-1][N2_W-1:N2_W-2]};
		assign trial = (RW + 2)'({root_q[k-1], 2'b01});
		assign take  = remn >= trial;
		assign diff  = remn - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				val_q[k]  <= {val_q[k-1][N2_W-3:0], 2'b00};
				rem_q[k]  <= take ? diff[RW-1:0] : remn[RW-1:0];
				root_q[k] <= {root_q[k-1][ROOT_W-2:0], take};
			end
		end
	end

	assign root = root_q[ROOT_W];

endmodule

// ===== hw/rtl/dpp_delay.sv =====
// ----------------------------------------------------------------------------
// dpp_delay
// Side-band delay line with valid bits, kept in step with an arithmetic unit.
// ----------------------------------------------------------------------------
module dpp_delay #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  logic [W-1:0] data_in,
	output logic         vld_out,
	output logic [W-1:0] data_out
);
	logic         vld_q  [D];
	logic [W-1:0] data_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= vld_in;
			for (int i = 1; i < D; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q[0] <= data_in;
			for (int i = 1; i < D; i++) data_q[i] <= data_q[i-1];
		end
	end

	assign vld_out  = vld_q[D-1];
	assign data_out = data_q[D-1];

endmodule

// ===== hw/rtl/depth_pixel_to_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Depth pixel to coloured 3D point: field-of-view ray, unit normalisation,
// scaling by depth over depth scale, signed Q7.16 saturated output.
//
// Channel  Dir  Word
// s_*      in   tdata: column, row, depth_raw, red, green, blue; tlast: frame end
// m_*      out  tdata: x, y, z, red, green, blue; tuser: point valid; tlast: frame end
// cfg_*    in   write enable, register index, data
//
// One word per cycle while the output is not stalled; data passes through the 31-bit ray
// dividers, the 32-step square root and the 24-bit point dividers.
// Whole pipeline advances on one enable; an input skid stage takes one word
// while the output is stalled. Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module depth_pixel_to_point #(
	parameter int COORD_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dpp_pkg::ADDR_W-1:0] cfg_addr,
	input  logic [dpp_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// column, row, depth_raw, red_in, green_in, blue_in, zero pad
	input  logic [((2*COORD_BITS+40+7)/8)*8-1:0] s_tdata,
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// point_x, point_y, point_z, red_out, green_out, blue_out
	output logic [95:0]                m_tdata,
	// point_valid
	output logic                       m_tuser,
	output logic                       m_tlast
);
	import dpp_pkg::*;

	localparam int IN_W   = ((2*COORD_BITS+40+7)/8)*8;
	localparam int CB     = COORD_BITS;
	localparam int DM_W   = (CB + 1 > REF_W) ? CB + 1 : REF_W;
	localparam int PROD_W = TAN_W + DM_W;
	localparam int RN_W   = PROD_W + 1;

	typedef struct packed {
		logic     neg_x;
		logic     neg_y;
		dpp_pix_t pix;
	} side_a_t;

	typedef struct packed {
		logic [VEC_W-1:0] xm;
		logic             xn;
		logic [VEC_W-1:0] ym;
		logic             yn;
		dpp_pix_t         pix;
	} side_b_t;

	typedef struct packed {
		logic     xn;
		logic     yn;
		dpp_pix_t pix;
	} side_c_t;

	// configuration
	logic [TAN_W-1:0]   tan_h_q, tan_v_q;
	logic [REF_W-1:0]   width_q, height_q;
	logic [SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_h_q  <= TAN_W'(37837);
			tan_v_q  <= TAN_W'(27146);
			width_q  <= REF_W'(320);
			height_q <= REF_W'(240);
			scale_q  <= SCALE_W'(1000);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TAN_H:  tan_h_q  <= cfg_data[TAN_W-1:0];
				REG_TAN_V:  tan_v_q  <= cfg_data[TAN_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[REF_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[REF_W-1:0];
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [REF_W-1:0]   ref_w, ref_h;
	logic [SCALE_W-1:0] scale_e;
	assign ref_w   = (width_q == '0) ? REF_W'(1) : width_q;
	assign ref_h   = (height_q == '0) ? REF_W'(1) : height_q;
	assign scale_e = (scale_q == '0) ? SCALE_W'(1) : scale_q;

	// global advance and input skid
	logic            en;
	logic            out_vld_q;
	logic            skid_full_q;
	logic [IN_W-1:0] skid_data_q;
	logic            skid_last_q;
	logic [IN_W-1:0] src_data;
	logic            src_last, src_vld;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = !skid_full_q;
	assign src_data = skid_full_q ? skid_data_q : s_tdata;
	assign src_last = skid_full_q ? skid_last_q : s_tlast;
	assign src_vld  = skid_full_q || s_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_tvalid && s_tready) begin
			skid_data_q <= s_tdata;
			skid_last_q <= s_tlast;
		end
	end

	// stage 1: unpack
	logic           v_s1;
	logic [CB-1:0]  col_s1, row_s1;
	dpp_pix_t       pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= src_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1           <= src_data[CB-1:0];
			row_s1           <= src_data[2*CB-1:CB];
			pix_s1.depth     <= src_data[2*CB+15:2*CB];
			pix_s1.red       <= src_data[2*CB+23:2*CB+16];
			pix_s1.green     <= src_data[2*CB+31:2*CB+24];
			pix_s1.blue      <= src_data[2*CB+39:2*CB+32];
			pix_s1.frame_end <= src_last;
		end
	end

	// stage 2: offset from centre times tangent
	logic [DM_W-1:0] ax, ay, rx, ry, dmx, dmy;
	logic            negx, negy;
	assign ax   = DM_W'({col_s1, 1'b1});
	assign ay   = DM_W'({row_s1, 1'b1});
	assign rx   = DM_W'(ref_w);
	assign ry   = DM_W'(ref_h);
	assign negx = ax < rx;
	assign negy = ay < ry;
	assign dmx  = negx ? rx - ax : ax - rx;
	assign dmy  = negy ? ry - ay : ay - ry;

	logic              v_s2;
	logic [PROD_W-1:0] prodx_s2, prody_s2;
	side_a_t           side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prodx_s2      <= PROD_W'(tan_h_q) * PROD_W'(dmx);
			prody_s2      <= PROD_W'(tan_v_q) * PROD_W'(dmy);
			side_s2.neg_x <= negx;
			side_s2.neg_y <= negy;
			side_s2.pix   <= pix_s1;
		end
	end

	// ray division by reference size
	logic [VEC_W-1:0] qx, qy;
	logic             ovfx, ovfy;
	logic             v_ra;
	side_a_t          side_ra;

	dpp_div #(.NUM_W(RN_W), .DEN_W(REF_W), .Q_W(VEC_W)) u_div_rx (
		.clk(clk), .en(en),
		.num(RN_W'(prodx_s2) + RN_W'(ref_w >> 1)), .den(ref_w),
		.quo(qx), .ovf(ovfx)
	);

	dpp_div #(.NUM_W(RN_W), .DEN_W(REF_W), .Q_W(VEC_W)) u_div_ry (
		.clk(clk), .en(en),
		.num(RN_W'(prody_s2) + RN_W'(ref_h >> 1)), .den(ref_h),
		.quo(qy), .ovf(ovfy)
	);

	dpp_delay #(.W($bits(side_a_t)), .D(VEC_W + 1)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(v_s2), .data_in(side_s2),
		.vld_out(v_ra), .data_out(side_ra)
	);

	logic [VEC_W-1:0] xm, ym;
	assign xm = ovfx ? VEC_MAX : qx;
	assign ym = ovfy ? VEC_MAX : qy;

	// stage 4: saturated ray
	logic    v_s4;
	side_b_t ray_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_ra;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4.xm  <= xm;
			ray_s4.ym  <= ym;
			ray_s4.xn  <= side_ra.neg_x && (xm != '0);
			ray_s4.yn  <= side_ra.neg_y && (ym != '0);
			ray_s4.pix <= side_ra.pix;
		end
	end

	// stage 5: squares
	logic                 v_s5;
	logic [2*VEC_W-1:0]   sqx_s5, sqy_s5;
	side_b_t              ray_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s5 <= ray_s4.xm * ray_s4.xm;
			sqy_s5 <= ray_s4.ym * ray_s4.ym;
			ray_s5 <= ray_s4;
		end
	end

	// norm
	logic [ROOT_W-1:0] nrm;
	logic              v_rb;
	side_b_t           ray_rb;

	dpp_isqrt u_isqrt (
		.clk(clk), .en(en),
		.val(N2_W'(sqx_s5) + N2_W'(sqy_s5) + {{(N2_W-33){1'b0}}, 1'b1, 32'd0}),
		.root(nrm)
	);

	dpp_delay #(.W($bits(side_b_t)), .D(ROOT_W + 1)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(v_s5), .data_in(ray_s5),
		.vld_out(v_rb), .data_out(ray_rb)
	);

	// stage 6: denominator
	logic             v_s6;
	logic [DEN_W-1:0] den_s6;
	side_b_t          ray_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_rb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= DEN_W'(nrm) * DEN_W'(scale_e);
			ray_s6 <= ray_rb;
		end
	end

	// stage 7: numerators
	localparam int PX_W = VEC_W + DEPTH_W;

	logic             v_s7;
	logic [DEN_W-1:0] den_s7;
	logic [PX_W-1:0]  px_s7, py_s7;
	side_c_t          side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7      <= den_s6;
			px_s7       <= PX_W'(ray_s6.xm) * PX_W'(ray_s6.pix.depth);
			py_s7       <= PX_W'(ray_s6.ym) * PX_W'(ray_s6.pix.depth);
			side_s7.xn  <= ray_s6.xn;
			side_s7.yn  <= ray_s6.yn;
			side_s7.pix <= ray_s6.pix;
		end
	end

	logic [PNUM_W-1:0] half_den;
	assign half_den = PNUM_W'(den_s7 >> 1);

	// point division
	logic [PQ_W-1:0] pqx, pqy, pqz;
	logic            povx, povy, povz;
	logic            v_rc;
	side_c_t         side_rc;

	dpp_div #(.NUM_W(PNUM_W), .DEN_W(DEN_W), .Q_W(PQ_W)) u_div_px (
		.clk(clk), .en(en),
		.num(PNUM_W'({px_s7, 16'd0}) + half_den), .den(den_s7),
		.quo(pqx), .ovf(povx)
	);

	dpp_div #(.NUM_W(PNUM_W), .DEN_W(DEN_W), .Q_W(PQ_W)) u_div_py (
		.clk(clk), .en(en),
		.num(PNUM_W'({py_s7, 16'd0}) + half_den), .den(den_s7),
		.quo(pqy), .ovf(povy)
	);

	dpp_div #(.NUM_W(PNUM_W), .DEN_W(DEN_W), .Q_W(PQ_W)) u_div_pz (
		.clk(clk), .en(en),
		.num(PNUM_W'({side_s7.pix.depth, 32'd0}) + half_den), .den(den_s7),
		.quo(pqz), .ovf(povz)
	);

	dpp_delay #(.W($bits(side_c_t)), .D(PQ_W + 1)) u_dly_c (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(v_s7), .data_in(side_s7),
		.vld_out(v_rc), .data_out(side_rc)
	);

	// output register
	logic             hit;
	logic [OUT_W-1:0] x_q, y_q, z_q;
	logic [COL_W-1:0] red_q, green_q, blue_q;
	logic             pvalid_q, last_q;

	assign hit = side_rc.pix.depth != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= v_rc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q      <= hit ? sat_out(pqx, povx, side_rc.xn) : '0;
			y_q      <= hit ? sat_out(pqy, povy, side_rc.yn) : '0;
			z_q      <= hit ? sat_out(pqz, povz, 1'b0) : '0;
			red_q    <= hit ? side_rc.pix.red : '0;
			green_q  <= hit ? side_rc.pix.green : '0;
			blue_q   <= hit ? side_rc.pix.blue : '0;
			pvalid_q <= hit;
			last_q   <= side_rc.pix.frame_end;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {blue_q, green_q, red_q, z_q, y_q, x_q};
	assign m_tuser  = pvalid_q;
	assign m_tlast  = last_q;

endmodule
